/* rtl/ucl_pkg.sv */
// Shared types and constants for the UART console line buffer.
// Register offsets, ID values, prompt patterns, sequencer states and the
// command/status structs between controller and datapath. No dependencies.
package ucl_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 48;  // offset[11:0], write_data[43:12]
    localparam int M_TDATA_W = 40;  // read_data[31:0], console_byte[39:32]

    // Access kinds and result kinds
    localparam logic ACT_READ     = 1'b0;
    localparam logic KIND_READ    = 1'b0;
    localparam logic KIND_CONSOLE = 1'b1;

    // Register offsets
    localparam logic [11:0] OFF_DR   = 12'h000;
    localparam logic [11:0] OFF_FR   = 12'h018;
    localparam logic [11:0] OFF_CR   = 12'h030;
    localparam logic [11:0] OFF_IMSC = 12'h038;
    localparam logic [11:0] OFF_PID0 = 12'hFE0;
    localparam logic [11:0] OFF_PID1 = 12'hFE4;
    localparam logic [11:0] OFF_PID2 = 12'hFE8;
    localparam logic [11:0] OFF_CID0 = 12'hFF0;
    localparam logic [11:0] OFF_CID1 = 12'hFF4;
    localparam logic [11:0] OFF_CID2 = 12'hFF8;
    localparam logic [11:0] OFF_CID3 = 12'hFFC;

    // Register values
    localparam logic [31:0] CR_RESET = 32'h0000_0301;
    localparam logic [31:0] FR_VALUE = 32'h0000_0090;
    localparam logic [31:0] PID0_VAL = 32'h0000_0011;
    localparam logic [31:0] PID1_VAL = 32'h0000_0010;
    localparam logic [31:0] PID2_VAL = 32'h0000_0014;
    localparam logic [31:0] CID0_VAL = 32'h0000_000D;
    localparam logic [31:0] CID1_VAL = 32'h0000_00F0;
    localparam logic [31:0] CID2_VAL = 32'h0000_0005;
    localparam logic [31:0] CID3_VAL = 32'h0000_00B1;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Prompt patterns, element 0 is the last character of the prompt
    localparam int HIST_DEPTH = 10;
    localparam logic [6:0][7:0] PAT_LOGIN  = "login: ";
    localparam logic [9:0][7:0] PAT_PASS   = "Password: ";
    localparam logic [1:0][7:0] PAT_HASH   = "# ";
    localparam logic [1:0][7:0] PAT_DOLLAR = "$ ";

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STORE,
        ST_CHECK,
        ST_RD,
        ST_EMIT,
        ST_NL
    } ucl_state_t;

    typedef struct packed {
        logic capture;      // latch the input transfer
        logic write_reg;    // register write (control or mask)
        logic load_read;    // load read result into output register
        logic store_byte;   // append byte to line store
        logic drain_start;  // reset drain index
        logic emit_byte;    // load line byte into output register
        logic emit_nl;      // load newline into output register
        logic clear_len;    // empty the line store
        logic last_flag;    // tlast for an emitted line byte
    } ucl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_data;
        logic is_crlf;
        logic len_zero;
        logic full;
        logic prompt;
        logic idx_last;
        logic out_free;
    } ucl_status_t;

endpackage

/* rtl/uart_console_line_buffer_regs_top.sv */
// Top level of the UART console line buffer register block.
// Instantiates ucl_ctrl and ucl_dpath; depends on ucl_pkg.
//
// Usage:
//   s_axis carries one bus access per transfer: tuser is the access kind
//   (0 read, 1 write), tdata holds offset and write value.
//   m_axis carries results: tuser is the result kind (0 read data, 1 console
//   byte), tlast marks the final result of one access.
//   A read gives one result, loaded into the output register once it is
//   free. A write to the control or mask register gives no result. A data
//   register write that stores its byte then checks for a prompt; a CR or LF
//   on an empty line stores nothing. A line flush reads each stored byte
//   through the single registered read port of the line store, and a flush on
//   CR, LF or a full store ends with a newline. The block takes one access at
//   a time; tready is high only while it waits for the next one.
//   Reset sets control to 0x301, clears the mask and empties the line store;
//   no clearing pass is needed. When the receiver stalls, hold the result in
//   the output register and stall the sequencer until it is taken.
module uart_console_line_buffer_regs_top
    import ucl_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [11:0] offset, [43:12] write_data, pad
    input  logic                 s_axis_tuser,  // [0] action
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [31:0] read_data, [39:32] console_byte
    output logic                 m_axis_tuser,  // [0] result_kind
    output logic                 m_axis_tlast   // last_of_run
);

    ucl_cmd_t    cmd;
    ucl_status_t status;

    // Sequencer: decode, store, prompt check and drain steps
    ucl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Registers, line store and output register
    ucl_dpath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/ucl_ctrl.sv */
// Sequencer for the UART console line buffer.
// Decodes each captured access and steps the datapath through store and drain.
// Depends on ucl_pkg.
module ucl_ctrl
    import ucl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  ucl_status_t status,
    output ucl_cmd_t    cmd
);

    ucl_state_t state_reg, state_next;
    logic       nl_mode_reg, nl_mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            nl_mode_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nl_mode_reg <= nl_mode_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (status.is_read) begin
                    if (status.out_free) state_next = ST_IDLE;
                end else if (status.is_data) begin
                    if (status.is_crlf) begin
                        state_next = status.len_zero ? ST_IDLE : ST_RD;
                    end else if (status.full) begin
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_STORE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_STORE: state_next = ST_CHECK;
            ST_CHECK: begin
                state_next = status.prompt ? ST_RD : ST_IDLE;
            end
            ST_RD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) begin
                    if (!status.idx_last) state_next = ST_RD;
                    else if (nl_mode_reg)  state_next = ST_NL;
                    else                   state_next = ST_IDLE;
                end
            end
            ST_NL: begin
                if (status.out_free) state_next = status.is_crlf ? ST_IDLE : ST_STORE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd           = '0;
        nl_mode_next  = nl_mode_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.capture   = s_axis_tvalid;
            end
            ST_EXEC: begin
                if (status.is_read) begin
                    cmd.load_read = status.out_free;
                end else if (status.is_data) begin
                    if ((status.is_crlf && !status.len_zero) ||
                        (!status.is_crlf && status.full)) begin
                        cmd.drain_start = 1'b1;
                        nl_mode_next    = 1'b1;
                    end
                end else begin
                    cmd.write_reg = 1'b1;
                end
            end
            ST_STORE: cmd.store_byte = 1'b1;
            ST_CHECK: begin
                if (status.prompt) begin
                    cmd.drain_start = 1'b1;
                    nl_mode_next    = 1'b0;
                end
            end
            ST_RD: ;
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_byte = 1'b1;
                    cmd.last_flag = !nl_mode_reg && status.idx_last;
                    cmd.clear_len = !nl_mode_reg && status.idx_last;
                end
            end
            ST_NL: begin
                if (status.out_free) begin
                    cmd.emit_nl   = 1'b1;
                    cmd.clear_len = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/ucl_dpath.sv */
// Datapath for the UART console line buffer: registers, line store memory,
// prompt history, read decode and output register. Depends on ucl_pkg.
module ucl_dpath
    import ucl_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  ucl_cmd_t             cmd,
    output ucl_status_t          status,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int IDX_W = $clog2(LINE_DEPTH);
    localparam int LEN_W = $clog2(LINE_DEPTH + 1);

    logic                         action_reg;
    logic [11:0]                  offset_reg;
    logic [31:0]                  wdata_reg;
    logic [31:0]                  control_reg, irq_mask_reg;
    logic [7:0]                   line_mem [LINE_DEPTH];
    logic [7:0]                   rd_data_reg;
    logic [LEN_W-1:0]             len_reg, idx_reg;
    logic [HIST_DEPTH-1:0][7:0]   hist_reg;
    logic                         out_valid_reg, out_kind_reg, out_last_reg;
    logic [31:0]                  out_data_reg;
    logic [7:0]                   out_byte_reg;
    logic [31:0]                  read_val;
    logic [7:0]                   byte_in;
    logic                         out_free;

    assign byte_in  = wdata_reg[7:0];
    assign out_free = !out_valid_reg || m_axis_tready;

    // Capture the accepted transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_axis_tuser;
            offset_reg <= s_axis_tdata[11:0];
            wdata_reg  <= s_axis_tdata[43:12];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg  <= CR_RESET;
            irq_mask_reg <= '0;
        end else if (cmd.write_reg) begin
            if (offset_reg == OFF_CR)   control_reg  <= wdata_reg;
            if (offset_reg == OFF_IMSC) irq_mask_reg <= wdata_reg;
        end
    end

    // Line store: one write port at the fill level, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.store_byte) line_mem[len_reg[IDX_W-1:0]] <= byte_in;
        rd_data_reg <= line_mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_byte) hist_reg <= {hist_reg[HIST_DEPTH-2:0], byte_in};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            idx_reg <= '0;
        end else begin
            if (cmd.clear_len)       len_reg <= '0;
            else if (cmd.store_byte) len_reg <= len_reg + 1'b1;
            if (cmd.drain_start)     idx_reg <= '0;
            else if (cmd.emit_byte)  idx_reg <= idx_reg + 1'b1;
        end
    end

    always_comb begin
        unique case (offset_reg)
            OFF_FR:   read_val = FR_VALUE;
            OFF_CR:   read_val = control_reg;
            OFF_IMSC: read_val = irq_mask_reg;
            OFF_PID0: read_val = PID0_VAL;
            OFF_PID1: read_val = PID1_VAL;
            OFF_PID2: read_val = PID2_VAL;
            OFF_CID0: read_val = CID0_VAL;
            OFF_CID1: read_val = CID1_VAL;
            OFF_CID2: read_val = CID2_VAL;
            OFF_CID3: read_val = CID3_VAL;
            default:  read_val = '0;
        endcase
    end

    always_comb begin
        status          = '0;
        status.is_read  = action_reg == ACT_READ;
        status.is_data  = offset_reg == OFF_DR;
        status.is_crlf  = byte_in == CHAR_LF || byte_in == CHAR_CR;
        status.len_zero = len_reg == '0;
        status.full     = len_reg == LEN_W'(LINE_DEPTH);
        status.idx_last = (idx_reg + 1'b1) == len_reg;
        status.out_free = out_free;
        status.prompt   = (len_reg >= LEN_W'(7)  && hist_reg[6:0] == PAT_LOGIN)  ||
                          (len_reg >= LEN_W'(10) && hist_reg      == PAT_PASS)   ||
                          (len_reg >= LEN_W'(2)  && hist_reg[1:0] == PAT_HASH)   ||
                          (len_reg >= LEN_W'(2)  && hist_reg[1:0] == PAT_DOLLAR);
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_read || cmd.emit_byte || cmd.emit_nl) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_read) begin
            out_kind_reg <= KIND_READ;
            out_data_reg <= read_val;
            out_byte_reg <= '0;
            out_last_reg <= 1'b1;
        end else if (cmd.emit_byte) begin
            out_kind_reg <= KIND_CONSOLE;
            out_data_reg <= '0;
            out_byte_reg <= rd_data_reg;
            out_last_reg <= cmd.last_flag;
        end else if (cmd.emit_nl) begin
            out_kind_reg <= KIND_CONSOLE;
            out_data_reg <= '0;
            out_byte_reg <= CHAR_LF;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_byte_reg, out_data_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(LINE_DEPTH))
        else $error("line length above store depth");

    a_store_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_byte |-> len_reg < LEN_W'(LINE_DEPTH))
        else $error("byte stored into a full line store");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_read || cmd.emit_byte || cmd.emit_nl) |-> out_free)
        else $error("output register overwritten while held");

    a_drain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_byte |-> idx_reg < len_reg)
        else $error("drain index past line length");

endmodule
